>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Wraps concurrent assertions so that synthesis sees nothing of them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define VNA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define VNA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define VNA_ASSERT(lbl, prop, msg)
`define VNA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared constants, command codes and types of the vertex normal accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

	localparam int VERTEX_COUNT_DEF = 256;
	localparam int COORD_BITS_DEF   = 16;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 8;
	localparam int POS_W  = 16;
	localparam int NORM_W = 16;
	localparam int SUM_W  = 40;

	// Normalizer widths: shifted magnitudes stay below 2^31, their squared
	// sum below 2^64, its root below 2^32, and a quotient is at most 2^14.
	localparam int MAG_W      = 31;
	localparam int SQ_W       = 64;
	localparam int LEN_W      = 32;
	localparam int QUO_W      = 15;
	localparam int UNIT_SHIFT = 14;

	localparam logic [QUO_W-1:0] UNIT_ONE = 15'd16384;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TRI   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	typedef struct packed {
		logic signed [SUM_W-1:0] x;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] z;
	} sum_vec_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] x;
		logic signed [NORM_W-1:0] y;
		logic signed [NORM_W-1:0] z;
		logic                     zero;
	} norm_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} norm_status_t;

endpackage

`default_nettype wire

>>> rtl/vna_in_if.sv
// ----------------------------------------------------------------------------
// vna_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface vna_in_if import vna_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [IDX_W-1:0]        vertex_index;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [IDX_W-1:0]        corner_a;
	logic [IDX_W-1:0]        corner_b;
	logic [IDX_W-1:0]        corner_c;

	modport source (output valid, cmd, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, cmd, vertex_index, pos_x, pos_y, pos_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

`default_nettype wire

>>> rtl/vna_out_if.sv
// ----------------------------------------------------------------------------
// vna_out_if
// Result channel: valid/ready handshake with one queried unit normal.
// ----------------------------------------------------------------------------
`default_nettype none

interface vna_out_if import vna_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         out_vertex;
	logic signed [NORM_W-1:0] normal_x;
	logic signed [NORM_W-1:0] normal_y;
	logic signed [NORM_W-1:0] normal_z;
	logic                     zero_sum;
	logic                     saturated;

	modport source (output valid, out_vertex, normal_x, normal_y, normal_z,
		zero_sum, saturated, input ready);
	modport sink (input valid, out_vertex, normal_x, normal_y, normal_z,
		zero_sum, saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalizer: scales a sum vector to a Q1.14 unit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_norm import vna_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire sum_vec_t  sum,
	output norm_res_t      res,
	output norm_status_t   status
);

	localparam int SQP_W = 2 * MAG_W;
	localparam int NUM_W = MAG_W + QUO_W;

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_MAX   = 3'd1;
	localparam logic [2:0] N_SHIFT = 3'd2;
	localparam logic [2:0] N_SQ    = 3'd3;
	localparam logic [2:0] N_SQRT  = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;
	localparam logic [2:0] N_DONE  = 3'd6;

	logic [2:0]       state_q;
	logic [4:0]       cnt_q;
	logic [1:0]       comp_q;
	logic [2:0]       sign_q;
	logic [SUM_W-1:0] mag_q [3];
	logic [3:0]       k_q;
	logic [SQP_W-1:0] sq_q;
	logic [SQ_W-1:0]  acc_q;
	logic [SQ_W-1:0]  root_q;
	logic [SQ_W-1:0]  bit_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [QUO_W-1:0] lo_q;
	norm_res_t        res_q;

	logic [SUM_W-1:0]  m_max;
	logic [3:0]        k_calc;
	logic [MAG_W-1:0]  t_sel;
	logic [MAG_W-1:0]  sq_op;
	logic [SQ_W-1:0]   trial;
	logic              root_ge;
	logic [NUM_W-1:0]  num;
	logic [LEN_W:0]    rem2;
	logic              div_ge;
	logic [LEN_W:0]    rem_sub;
	logic [QUO_W-1:0]  q_full;
	logic [QUO_W-1:0]  q_clamp;
	logic [NORM_W-1:0] q_ext;
	logic [NORM_W-1:0] comp_val;

	function automatic logic [SUM_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
		mag_of = v[SUM_W-1] ? (~v + 1'b1) : v;
	endfunction

	// Largest magnitude and the right shift that brings it under 2^31.
	always_comb begin
		m_max = mag_q[0];
		if (mag_q[1] > m_max) begin
			m_max = mag_q[1];
		end
		if (mag_q[2] > m_max) begin
			m_max = mag_q[2];
		end
		k_calc = 4'd0;
		for (int i = 0; i < SUM_W - MAG_W; i++) begin
			if (m_max[MAG_W+i]) begin
				k_calc = 4'(i + 1);
			end
		end
	end

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_op = mag_q[0][MAG_W-1:0];
			2'd1:    sq_op = mag_q[1][MAG_W-1:0];
			default: sq_op = mag_q[2][MAG_W-1:0];
		endcase
		case (comp_q)
			2'd0:    t_sel = mag_q[0][MAG_W-1:0];
			2'd1:    t_sel = mag_q[1][MAG_W-1:0];
			default: t_sel = mag_q[2][MAG_W-1:0];
		endcase
	end

	// One square-root digit pair per cycle.
	assign trial   = root_q + bit_q;
	assign root_ge = acc_q >= trial;

	// Restoring division, one quotient bit per cycle. The rounding term
	// keeps the numerator below len * 2^15, so the quotient fits 15 bits.
	assign num      = {t_sel, {UNIT_SHIFT{1'b0}}} + NUM_W'(len_q >> 1);
	assign rem2     = {rem_q, lo_q[QUO_W-1]};
	assign div_ge   = rem2 >= {1'b0, len_q};
	assign rem_sub  = div_ge ? (rem2 - {1'b0, len_q}) : rem2;
	assign q_full   = {quo_q[QUO_W-2:0], div_ge};
	assign q_clamp  = (q_full > UNIT_ONE) ? UNIT_ONE : q_full;
	assign q_ext    = NORM_W'(q_clamp);
	assign comp_val = sign_q[comp_q] ? (~q_ext + 1'b1) : q_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
		end else begin
			case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= N_MAX;
					end
				end
				N_MAX: begin
					state_q <= (m_max == '0) ? N_DONE : N_SHIFT;
				end
				N_SHIFT: begin
					state_q <= N_SQ;
					cnt_q   <= '0;
				end
				N_SQ: begin
					if (cnt_q == 5'd3) begin
						state_q <= N_SQRT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				N_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						state_q <= N_DIV;
						comp_q  <= '0;
					end
				end
				N_DIV: begin
					if (cnt_q == 5'(QUO_W)) begin
						cnt_q <= '0;
						if (comp_q == 2'd2) begin
							state_q <= N_DONE;
						end else begin
							comp_q <= comp_q + 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					sign_q   <= {sum.z[SUM_W-1], sum.y[SUM_W-1], sum.x[SUM_W-1]};
					mag_q[0] <= mag_of(sum.x);
					mag_q[1] <= mag_of(sum.y);
					mag_q[2] <= mag_of(sum.z);
				end
			end
			N_MAX: begin
				k_q <= k_calc;
				res_q <= '{x: '0, y: '0, z: '0, zero: (m_max == '0)};
			end
			N_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag_q[i] >> k_q;
				end
				acc_q <= '0;
			end
			N_SQ: begin
				if (cnt_q != 5'd3) begin
					sq_q <= SQP_W'(sq_op) * SQP_W'(sq_op);
				end
				if (cnt_q != 5'd0) begin
					acc_q <= acc_q + SQ_W'(sq_q);
				end
				root_q <= '0;
				bit_q  <= SQ_W'(1) << (SQ_W - 2);
			end
			N_SQRT: begin
				if (root_ge) begin
					acc_q  <= acc_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (cnt_q == 5'd31) begin
					len_q <= root_ge ? LEN_W'((root_q >> 1) + bit_q) : LEN_W'(root_q >> 1);
				end
			end
			N_DIV: begin
				if (cnt_q == 5'd0) begin
					rem_q <= LEN_W'(num[NUM_W-1:QUO_W]);
					lo_q  <= num[QUO_W-1:0];
					quo_q <= '0;
				end else begin
					rem_q <= rem_sub[LEN_W-1:0];
					lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
					quo_q <= q_full;
					if (cnt_q == 5'(QUO_W)) begin
						case (comp_q)
							2'd0:    res_q.x <= comp_val;
							2'd1:    res_q.y <= comp_val;
							default: res_q.z <= comp_val;
						endcase
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res    = res_q;
	assign status = '{busy: (state_q != N_IDLE), done: (state_q == N_DONE)};

endmodule

`default_nettype wire

>>> rtl/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted vertex normal accumulation over position and sum memories.
// ----------------------------------------------------------------------------
// Load: the next command is taken in the following cycle.
// Add triangle: three position reads, a difference step, a cross product on
// one shared multiplier and three read-modify-write passes on the sum memory.
// Query: the result is registered after the normalizer's 32-step square root
// and its three divisions, one per component; a zero sum skips both.
// Reset: a clearing pass over all VERTEX_COUNT entries zeroes the sum memory first.
`default_nettype none

`include "assert_macros.svh"

module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	vna_in_if.sink    req,
	vna_out_if.source rsp
);

	// Address width, coordinate difference width, product and cross widths.
	localparam int AW    = $clog2(VERTEX_COUNT);
	localparam int DW    = COORD_BITS + 1;
	localparam int PRD_W = 2 * DW;
	localparam int CW    = PRD_W + 1;
	localparam int ADD_W = ((CW > SUM_W) ? CW : SUM_W) + 1;
	localparam int PW    = 3 * COORD_BITS;
	localparam int SW    = 3 * SUM_W + 1;

	localparam logic [AW-1:0] CLR_LAST = AW'(VERTEX_COUNT - 1);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_RDA    = 4'd2;
	localparam logic [3:0] ST_RDB    = 4'd3;
	localparam logic [3:0] ST_RDC    = 4'd4;
	localparam logic [3:0] ST_DIFF   = 4'd5;
	localparam logic [3:0] ST_CROSS  = 4'd6;
	localparam logic [3:0] ST_ACC_RD = 4'd7;
	localparam logic [3:0] ST_ACC_WR = 4'd8;
	localparam logic [3:0] ST_Q_RD   = 4'd9;
	localparam logic [3:0] ST_Q_WAIT = 4'd10;
	localparam logic [3:0] ST_NORM   = 4'd11;
	localparam logic [3:0] ST_OUT    = 4'd12;

	// Sequencer and control state.
	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    cn_q;
	logic [2:0]    mstep_q;
	logic          out_valid_q;

	// Command payload held for the duration of one command.
	logic [AW-1:0]    corner_q [3];
	logic [IDX_W-1:0] vertex_q;
	logic             oor_q;
	logic             sat_q;

	// Geometry datapath.
	logic signed [COORD_BITS-1:0] pa_q [3];
	logic signed [COORD_BITS-1:0] pb_q [3];
	logic signed [DW-1:0]         u_q [3];
	logic signed [DW-1:0]         w_q [3];
	logic signed [PRD_W-1:0]      prod_q;
	logic signed [CW-1:0]         cross_q [3];

	// Result register.
	logic [IDX_W-1:0]         out_vertex_q;
	logic signed [NORM_W-1:0] out_x_q;
	logic signed [NORM_W-1:0] out_y_q;
	logic signed [NORM_W-1:0] out_z_q;
	logic                     out_zero_q;
	logic                     out_sat_q;

	// Memory ports.
	logic          pos_we;
	logic [PW-1:0] pos_wdata;
	logic [AW-1:0] pos_raddr;
	logic [PW-1:0] pos_rdata;
	logic          sum_we;
	logic [AW-1:0] sum_waddr;
	logic [SW-1:0] sum_wdata;
	logic [AW-1:0] sum_raddr;
	logic [SW-1:0] sum_rdata;

	logic signed [COORD_BITS-1:0] rd_pos [3];
	sum_vec_t     sum_old;
	sum_vec_t     sum_new;
	logic         sat_old;
	logic [2:0]   clamped;

	logic         accept;
	logic         vi_ok;
	logic         tri_ok;
	logic         load_we;
	logic         out_free;
	logic         out_load;
	logic [AW-1:0] corner_sel;
	logic signed [DW-1:0] mul_a;
	logic signed [DW-1:0] mul_b;

	norm_res_t    norm_res;
	norm_status_t norm_st;

	// An incoming coordinate keeps its low COORD_BITS bits as a signed value;
	// a wider coordinate takes the 16-bit field zero-extended.
	function automatic logic signed [COORD_BITS-1:0] coord_of(
		input logic signed [POS_W-1:0] raw);
		coord_of = COORD_BITS'($unsigned(raw));
	endfunction

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		in_range = 32'(idx) < 32'(VERTEX_COUNT);
	endfunction

	// Saturating accumulate: the top bit of the result flags a clamp.
	function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] acc,
		input logic signed [CW-1:0] inc);
		logic signed [ADD_W-1:0] r;
		r = ADD_W'(acc) + ADD_W'(inc);
		if (r > ADD_W'(SUM_MAX)) begin
			sat_add = {1'b1, SUM_MAX};
		end else if (r < ADD_W'(SUM_MIN)) begin
			sat_add = {1'b1, SUM_MIN};
		end else begin
			sat_add = {1'b0, r[SUM_W-1:0]};
		end
	endfunction

	assign accept  = req.valid && req.ready;
	assign vi_ok   = in_range(req.vertex_index);
	assign tri_ok  = in_range(req.corner_a) && in_range(req.corner_b) &&
		in_range(req.corner_c);
	assign load_we = accept && (req.cmd == CMD_LOAD) && vi_ok;

	// Commands are taken only between commands; a finished query result may
	// still be waiting in the output register.
	assign req.ready = state_q == ST_IDLE;

	// ------------------------------------------------------------------
	// Position memory: written by a load, read once per triangle corner.
	// ------------------------------------------------------------------
	assign pos_we    = load_we;
	assign pos_wdata = {coord_of(req.pos_z), coord_of(req.pos_y), coord_of(req.pos_x)};

	always_comb begin
		case (state_q)
			ST_RDA:  pos_raddr = corner_q[0];
			ST_RDB:  pos_raddr = corner_q[1];
			default: pos_raddr = corner_q[2];
		endcase
	end

	vna_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (AW'(req.vertex_index)),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	assign rd_pos[0] = pos_rdata[COORD_BITS-1:0];
	assign rd_pos[1] = pos_rdata[2*COORD_BITS-1:COORD_BITS];
	assign rd_pos[2] = pos_rdata[3*COORD_BITS-1:2*COORD_BITS];

	// ------------------------------------------------------------------
	// Sum memory: {sat mark, x, y, z}. The accumulate pass reads a corner's
	// entry and writes it back in the next cycle before the next corner is
	// read, so a repeated corner always sees its updated sum.
	// ------------------------------------------------------------------
	always_comb begin
		case (cn_q)
			2'd0:    corner_sel = corner_q[0];
			2'd1:    corner_sel = corner_q[1];
			default: corner_sel = corner_q[2];
		endcase
	end

	assign sum_old = sum_vec_t'(sum_rdata[3*SUM_W-1:0]);
	assign sat_old = sum_rdata[3*SUM_W];

	always_comb begin
		{clamped[0], sum_new.x} = sat_add(sum_old.x, cross_q[0]);
		{clamped[1], sum_new.y} = sat_add(sum_old.y, cross_q[1]);
		{clamped[2], sum_new.z} = sat_add(sum_old.z, cross_q[2]);
	end

	always_comb begin
		sum_we    = 1'b0;
		sum_waddr = corner_sel;
		sum_wdata = {sat_old | (|clamped), sum_new};
		if (state_q == ST_CLEAR) begin
			sum_we    = 1'b1;
			sum_waddr = clr_q;
			sum_wdata = '0;
		end else if (load_we) begin
			sum_we    = 1'b1;
			sum_waddr = AW'(req.vertex_index);
			sum_wdata = '0;
		end else if (state_q == ST_ACC_WR) begin
			sum_we = 1'b1;
		end
	end

	assign sum_raddr = (state_q == ST_Q_RD) ? AW'(vertex_q) : corner_sel;

	vna_ram #(.WIDTH(SW), .DEPTH(VERTEX_COUNT)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// ------------------------------------------------------------------
	// Cross product (b-a)x(c-a) on one multiplier: six products, each
	// registered and folded into its component in the next cycle.
	// ------------------------------------------------------------------
	always_comb begin
		case (mstep_q)
			3'd0:    begin mul_a = u_q[1]; mul_b = w_q[2]; end
			3'd1:    begin mul_a = u_q[2]; mul_b = w_q[1]; end
			3'd2:    begin mul_a = u_q[2]; mul_b = w_q[0]; end
			3'd3:    begin mul_a = u_q[0]; mul_b = w_q[2]; end
			3'd4:    begin mul_a = u_q[0]; mul_b = w_q[1]; end
			3'd5:    begin mul_a = u_q[1]; mul_b = w_q[0]; end
			default: begin mul_a = '0;     mul_b = '0;     end
		endcase
	end

	// ------------------------------------------------------------------
	// Normalizer for queries.
	// ------------------------------------------------------------------
	vna_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_Q_WAIT),
		.sum    (sum_old),
		.res    (norm_res),
		.status (norm_st)
	);

	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = ((state_q == ST_NORM && norm_st.done) || state_q == ST_OUT) &&
		out_free;

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cn_q        <= '0;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_TRI: begin
								if (tri_ok) begin
									state_q <= ST_RDA;
								end
							end
							CMD_QUERY: begin
								state_q <= vi_ok ? ST_Q_RD : ST_OUT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB:  state_q <= ST_RDC;
				ST_RDC:  state_q <= ST_DIFF;
				ST_DIFF: begin
					state_q <= ST_CROSS;
					mstep_q <= '0;
				end
				ST_CROSS: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 3'd6) begin
						state_q <= ST_ACC_RD;
						cn_q    <= '0;
					end
				end
				ST_ACC_RD: state_q <= ST_ACC_WR;
				ST_ACC_WR: begin
					if (cn_q == 2'd2) begin
						state_q <= ST_IDLE;
					end else begin
						cn_q    <= cn_q + 1'b1;
						state_q <= ST_ACC_RD;
					end
				end
				ST_Q_RD:   state_q <= ST_Q_WAIT;
				ST_Q_WAIT: state_q <= ST_NORM;
				ST_NORM: begin
					if (norm_st.done) begin
						state_q <= out_free ? ST_IDLE : ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			vertex_q    <= req.vertex_index;
			oor_q       <= !vi_ok;
			corner_q[0] <= AW'(req.corner_a);
			corner_q[1] <= AW'(req.corner_b);
			corner_q[2] <= AW'(req.corner_c);
		end
		if (state_q == ST_RDB) begin
			pa_q <= rd_pos;
		end
		if (state_q == ST_RDC) begin
			pb_q <= rd_pos;
		end
		if (state_q == ST_DIFF) begin
			for (int i = 0; i < 3; i++) begin
				u_q[i] <= DW'(pb_q[i]) - DW'(pa_q[i]);
				w_q[i] <= DW'(rd_pos[i]) - DW'(pa_q[i]);
			end
		end
		if (state_q == ST_CROSS) begin
			prod_q <= PRD_W'(mul_a) * PRD_W'(mul_b);
			case (mstep_q)
				3'd1:    cross_q[0] <= CW'(prod_q);
				3'd2:    cross_q[0] <= cross_q[0] - CW'(prod_q);
				3'd3:    cross_q[1] <= CW'(prod_q);
				3'd4:    cross_q[1] <= cross_q[1] - CW'(prod_q);
				3'd5:    cross_q[2] <= CW'(prod_q);
				3'd6:    cross_q[2] <= cross_q[2] - CW'(prod_q);
				default: begin
				end
			endcase
		end
		if (state_q == ST_Q_WAIT) begin
			sat_q <= sat_old;
		end
		if (out_load) begin
			out_vertex_q <= vertex_q;
			if (oor_q) begin
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_z_q    <= '0;
				out_zero_q <= 1'b1;
				out_sat_q  <= 1'b0;
			end else begin
				out_x_q    <= norm_res.x;
				out_y_q    <= norm_res.y;
				out_z_q    <= norm_res.z;
				out_zero_q <= norm_res.zero;
				out_sat_q  <= sat_q;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_vertex = out_vertex_q;
	assign rsp.normal_x   = out_x_q;
	assign rsp.normal_y   = out_y_q;
	assign rsp.normal_z   = out_z_q;
	assign rsp.zero_sum   = out_zero_q;
	assign rsp.saturated  = out_sat_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`VNA_ASSERT(a_clear_blocks_input, (state_q == ST_CLEAR) |-> !req.ready, "command taken during clearing pass")
	`VNA_ASSERT(a_norm_done_in_query, norm_st.done |-> (state_q == ST_NORM), "normalizer finished outside a query")
	`VNA_ASSERT_NEXT(a_norm_starts, (state_q == ST_Q_WAIT), norm_st.busy, "normalizer did not start")
	`VNA_ASSERT_NEXT(a_tri_busy, (accept && req.cmd == CMD_TRI && tri_ok), !req.ready, "triangle did not block input")

endmodule

`default_nettype wire
